// ===== hdl/centroid_track_association_unit_assert.svh =====
// Assertion macros for the centroid tracker RTL.
// Included by cta_datapath, which carries concurrent checks; no other dependencies.
`ifndef CENTROID_TRACK_ASSOCIATION_UNIT_ASSERT_SVH
`define CENTROID_TRACK_ASSOCIATION_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define CTA_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CTA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/cta_pkg.sv =====
// Shared types, codes and widths for the centroid tracker.
// Used by cta_ctrl, cta_datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package cta_pkg;

    // Default build sizes.
    localparam int DEF_MAX_TRACKS = 16;
    localparam int DEF_COORD_BITS = 12;

    // Fixed field widths.
    localparam int OP_W   = 2;
    localparam int QK_W   = 2;
    localparam int STAT_W = 2;
    localparam int ID_W   = 16;
    localparam int AREA_W = 24;
    localparam int HOLD_W = 9;
    localparam int MD_W   = 12;
    localparam int MT_W   = 5;
    localparam int HF_W   = 8;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Opcodes of an input word.
    localparam logic [OP_W-1:0] OP_BEGIN  = 2'd0;
    localparam logic [OP_W-1:0] OP_REGION = 2'd1;
    localparam logic [OP_W-1:0] OP_END    = 2'd2;

    // Query kinds at end of frame.
    localparam logic [QK_W-1:0] QK_MIN_ID   = 2'd1;
    localparam logic [QK_W-1:0] QK_MAX_AREA = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_ACK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_MATCH = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NEW   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd3;

    // Register indexes (byte address bits 3:2).
    localparam logic [1:0] REG_MAX_DIST   = 2'd0;
    localparam logic [1:0] REG_MAX_TRACKS = 2'd1;
    localparam logic [1:0] REG_HOLD       = 2'd2;

    // Register reset values.
    localparam logic [MD_W-1:0] RST_MAX_DIST   = 12'd100;
    localparam logic [MT_W-1:0] RST_MAX_TRACKS = 5'd16;
    localparam logic [HF_W-1:0] RST_HOLD       = 8'd5;

    // Hold counter floor: minus one in two's complement.
    localparam logic [HOLD_W-1:0] HOLD_FLOOR = 9'h1FF;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT,
        ST_FINISH
    } ctrl_state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;
        logic issue;
        logic commit;
        logic out_load;
    } dp_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic scan_done;
        logic pipe_empty;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== hdl/cta_ctrl.sv =====
// Sequencing state machine for the centroid tracker.
// Depends on cta_pkg; drives the command struct of cta_datapath.
`timescale 1ns / 1ps

module cta_ctrl import cta_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (stat.scan_done) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (stat.pipe_empty) state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (stat.out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Command outputs. No word is taken while reset is held.
    always_comb begin
        s_ready      = 1'b0;
        cmd.load     = 1'b0;
        cmd.issue    = 1'b0;
        cmd.commit   = 1'b0;
        cmd.out_load = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = aresetn;
                cmd.load = s_valid && aresetn;
            end
            ST_SCAN: begin
                cmd.issue = !stat.scan_done;
            end
            ST_DRAIN: begin
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
            end
            ST_FINISH: begin
                cmd.out_load = stat.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== hdl/cta_datapath.sv =====
// Track table memory, distance pipeline, compaction, query and result register.
// Depends on cta_pkg and the assertion macro header; commanded by cta_ctrl.
`timescale 1ns / 1ps
`include "centroid_track_association_unit_assert.svh"

module cta_datapath import cta_pkg::*; #(
    parameter int MAX_TRACKS = DEF_MAX_TRACKS,
    parameter int COORD_BITS = DEF_COORD_BITS,
    localparam int CNT_W = $clog2(MAX_TRACKS + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    input  logic [MD_W-1:0]       match_radius,
    input  logic [MT_W-1:0]       max_tracks,
    input  logic [HF_W-1:0]       hold_frames,
    input  logic [OP_W-1:0]       s_opcode,
    input  logic [COORD_BITS-1:0] s_pos_x,
    input  logic [COORD_BITS-1:0] s_pos_y,
    input  logic [AREA_W-1:0]     s_area,
    input  logic [QK_W-1:0]       s_query_kind,
    input  logic                  m_ready,
    output logic                  m_valid,
    output logic [STAT_W-1:0]     m_status,
    output logic [ID_W-1:0]       m_track_id,
    output logic [COORD_BITS-1:0] m_out_x,
    output logic [COORD_BITS-1:0] m_out_y,
    output logic [CNT_W-1:0]      m_track_count
);

    localparam int IDX_W  = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int DIST_W = (SQ_W + 1 > 2 * MD_W) ? SQ_W + 1 : 2 * MD_W;

    // Captured input word.
    logic [OP_W-1:0]       op_reg;
    logic [COORD_BITS-1:0] px_reg;
    logic [COORD_BITS-1:0] py_reg;
    logic [AREA_W-1:0]     area_reg;
    logic [QK_W-1:0]       qk_reg;

    // Table occupancy and id allocation.
    logic [CNT_W-1:0] live_reg, live_next;
    logic [ID_W-1:0]  next_id_reg, next_id_next;
    logic [CNT_W-1:0] rd_idx_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             room;

    // Track table memory.
    logic [ID_W-1:0]       mem_id   [MAX_TRACKS];
    logic [COORD_BITS-1:0] mem_x    [MAX_TRACKS];
    logic [COORD_BITS-1:0] mem_y    [MAX_TRACKS];
    logic [AREA_W-1:0]     mem_area [MAX_TRACKS];
    logic [HOLD_W-1:0]     mem_hold [MAX_TRACKS];

    // Registered read port.
    logic                  v1_reg;
    logic [IDX_W-1:0]      i1_reg;
    logic [ID_W-1:0]       rd_id_reg;
    logic [COORD_BITS-1:0] rd_x_reg;
    logic [COORD_BITS-1:0] rd_y_reg;
    logic [AREA_W-1:0]     rd_area_reg;
    logic [HOLD_W-1:0]     rd_hold_reg;

    // Write port.
    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [ID_W-1:0]       w_id;
    logic [COORD_BITS-1:0] w_x;
    logic [COORD_BITS-1:0] w_y;
    logic [AREA_W-1:0]     w_area;
    logic [HOLD_W-1:0]     w_hold;

    // Distance pipeline.
    logic                  v2_reg, v3_reg;
    logic [IDX_W-1:0]      i2_reg, i3_reg;
    logic [ID_W-1:0]       id2_reg, id3_reg;
    logic [COORD_BITS-1:0] dx_reg, dy_reg;
    logic [SQ_W-1:0]       sqx_reg, sqy_reg;
    logic [DIST_W-1:0]     sq_sum;
    logic [2*MD_W-1:0]     md_sq;
    logic [DIST_W-1:0]     best_reg;
    logic                  found_reg;
    logic [IDX_W-1:0]      best_idx_reg;
    logic [ID_W-1:0]       best_id_reg;

    // Compaction and query.
    logic                  keep;
    logic                  q_take;
    logic [CNT_W-1:0]      wr_ptr_reg;
    logic                  q_have_reg;
    logic [AREA_W-1:0]     q_key_reg;
    logic [COORD_BITS-1:0] ox_reg, oy_reg;

    // Pending result fields.
    logic [STAT_W-1:0] res_status_reg;
    logic [ID_W-1:0]   res_tid_reg;

    // Output register.
    logic                  m_valid_reg;
    logic [STAT_W-1:0]     m_status_reg;
    logic [ID_W-1:0]       m_tid_reg;
    logic [COORD_BITS-1:0] m_x_reg, m_y_reg;
    logic [CNT_W-1:0]      m_count_reg;

    assign rd_addr = rd_idx_reg[IDX_W-1:0];
    assign room    = (live_reg < CNT_W'(MAX_TRACKS)) && (8'(live_reg) < 8'(max_tracks));
    assign keep    = !rd_hold_reg[HOLD_W-1];
    assign md_sq   = (2*MD_W)'(match_radius) * (2*MD_W)'(match_radius);
    assign sq_sum  = DIST_W'(sqx_reg) + DIST_W'(sqy_reg);

    assign stat.scan_done  = (rd_idx_reg == live_reg);
    assign stat.pipe_empty = !v1_reg && !v2_reg && !v3_reg;
    assign stat.out_free   = !m_valid_reg || m_ready;

    // Capture the input word and step the scan address.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg     <= s_opcode;
            px_reg     <= s_pos_x;
            py_reg     <= s_pos_y;
            area_reg   <= s_area;
            qk_reg     <= s_query_kind;
            rd_idx_reg <= '0;
        end else if (cmd.issue) begin
            rd_idx_reg <= rd_idx_reg + CNT_W'(1);
        end
    end

    // Memory read port, one entry per cycle.
    always_ff @(posedge aclk) begin
        if (cmd.issue) begin
            rd_id_reg   <= mem_id[rd_addr];
            rd_x_reg    <= mem_x[rd_addr];
            rd_y_reg    <= mem_y[rd_addr];
            rd_area_reg <= mem_area[rd_addr];
            rd_hold_reg <= mem_hold[rd_addr];
        end
        i1_reg <= rd_addr;
    end

    // Write-port selection: ageing, compaction or the region update.
    always_comb begin
        we     = 1'b0;
        waddr  = i1_reg;
        w_id   = rd_id_reg;
        w_x    = rd_x_reg;
        w_y    = rd_y_reg;
        w_area = rd_area_reg;
        w_hold = rd_hold_reg;
        if (v1_reg && op_reg == OP_BEGIN) begin
            we     = (rd_hold_reg != HOLD_FLOOR);
            w_hold = rd_hold_reg - HOLD_W'(1);
        end else if (v1_reg && op_reg == OP_END) begin
            we    = keep;
            waddr = wr_ptr_reg[IDX_W-1:0];
        end else if (cmd.commit && op_reg == OP_REGION) begin
            w_x    = px_reg;
            w_y    = py_reg;
            w_area = area_reg;
            w_hold = HOLD_W'(hold_frames);
            if (found_reg) begin
                we    = 1'b1;
                waddr = best_idx_reg;
                w_id  = best_id_reg;
            end else begin
                we    = room;
                waddr = live_reg[IDX_W-1:0];
                w_id  = next_id_reg;
            end
        end
    end

    // Memory write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_id[waddr]   <= w_id;
            mem_x[waddr]    <= w_x;
            mem_y[waddr]    <= w_y;
            mem_area[waddr] <= w_area;
            mem_hold[waddr] <= w_hold;
        end
    end

    // Pipeline valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg && (op_reg == OP_REGION);
            v3_reg <= v2_reg;
        end
    end

    // Absolute differences, then squares.
    always_ff @(posedge aclk) begin
        dx_reg  <= (rd_x_reg > px_reg) ? rd_x_reg - px_reg : px_reg - rd_x_reg;
        dy_reg  <= (rd_y_reg > py_reg) ? rd_y_reg - py_reg : py_reg - rd_y_reg;
        i2_reg  <= i1_reg;
        id2_reg <= rd_id_reg;
        sqx_reg <= SQ_W'(dx_reg) * SQ_W'(dx_reg);
        sqy_reg <= SQ_W'(dy_reg) * SQ_W'(dy_reg);
        i3_reg  <= i2_reg;
        id3_reg <= id2_reg;
    end

    // Nearest-track search; strict compare keeps the earliest track on a tie.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            best_reg     <= DIST_W'(md_sq);
            found_reg    <= 1'b0;
            best_idx_reg <= '0;
            best_id_reg  <= '0;
        end else if (v3_reg && sq_sum < best_reg) begin
            best_reg     <= sq_sum;
            found_reg    <= 1'b1;
            best_idx_reg <= i3_reg;
            best_id_reg  <= id3_reg;
        end
    end

    // Query candidate test on a surviving track.
    always_comb begin
        q_take = 1'b0;
        if (qk_reg == QK_MIN_ID) begin
            q_take = !q_have_reg || (rd_id_reg < q_key_reg[ID_W-1:0]);
        end else if (qk_reg == QK_MAX_AREA) begin
            q_take = (rd_area_reg > q_key_reg);
        end
    end

    // Compaction pointer and query answer, both in one pass over the table.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            wr_ptr_reg <= '0;
            q_have_reg <= 1'b0;
            q_key_reg  <= '0;
            ox_reg     <= '0;
            oy_reg     <= '0;
        end else if (v1_reg && op_reg == OP_END && keep) begin
            wr_ptr_reg <= wr_ptr_reg + CNT_W'(1);
            if (q_take) begin
                q_have_reg <= 1'b1;
                q_key_reg  <= (qk_reg == QK_MIN_ID) ? AREA_W'(rd_id_reg) : rd_area_reg;
                ox_reg     <= rd_x_reg;
                oy_reg     <= rd_y_reg;
            end
        end
    end

    // Occupancy and id counter updates at commit.
    always_comb begin
        live_next    = live_reg;
        next_id_next = next_id_reg;
        if (cmd.commit) begin
            if (op_reg == OP_REGION && !found_reg && room) begin
                live_next    = live_reg + CNT_W'(1);
                next_id_next = next_id_reg + ID_W'(1);
            end else if (op_reg == OP_END) begin
                live_next = wr_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg    <= '0;
            next_id_reg <= '0;
        end else begin
            live_reg    <= live_next;
            next_id_reg <= next_id_next;
        end
    end

    // Status and id of the word being finished.
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            if (op_reg == OP_REGION && found_reg) begin
                res_status_reg <= STAT_MATCH;
                res_tid_reg    <= best_id_reg;
            end else if (op_reg == OP_REGION && room) begin
                res_status_reg <= STAT_NEW;
                res_tid_reg    <= next_id_reg;
            end else if (op_reg == OP_REGION) begin
                res_status_reg <= STAT_FULL;
                res_tid_reg    <= '0;
            end else begin
                res_status_reg <= STAT_ACK;
                res_tid_reg    <= '0;
            end
        end
    end

    // Output register; holds a finished word until it is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_status_reg <= res_status_reg;
            m_tid_reg    <= res_tid_reg;
            m_x_reg      <= ox_reg;
            m_y_reg      <= oy_reg;
            m_count_reg  <= live_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_track_id    = m_tid_reg;
    assign m_out_x       = m_x_reg;
    assign m_out_y       = m_y_reg;
    assign m_track_count = m_count_reg;

    // Checks on scan, compaction and result hand-over.
    `CTA_ASSERT_IMPL(a_issue_in_table, aclk, aresetn, cmd.issue, rd_idx_reg < live_reg, "read beyond live tracks")
    `CTA_ASSERT_IMPL(a_compact_behind, aclk, aresetn, v1_reg && op_reg == OP_END, wr_ptr_reg <= CNT_W'(i1_reg), "compaction write passed read")
    `CTA_ASSERT_NEXT(a_live_bounded, aclk, aresetn, cmd.commit, live_reg <= CNT_W'(MAX_TRACKS), "live count above table size")
    `CTA_ASSERT_IMPL(a_no_overwrite, aclk, aresetn, cmd.out_load, !m_valid_reg || m_ready, "result overwritten before taken")

endmodule

// ===== hdl/centroid_track_association_unit.sv =====
// Top level of the nearest-neighbour centroid tracker: register port and wiring.
// Depends on cta_pkg, cta_ctrl and cta_datapath.
//
//  Channel | Direction | Handshake         | Carries
//  s_      | in        | s_valid/s_ready   | opcode, position, area, query kind
//  m_      | out       | m_valid/m_ready   | status, track id, answer position, count
//  APB     | in        | psel/penable      | match radius, track limit, hold frames
//
// One word at a time. After acceptance a region word has its result made valid in these
// steps: one read of the track memory per table entry, a scan-end check, a drain of the
// distance pipeline, a commit and the result load. Other words skip two pipeline stages.
// The next word is taken once the result has been loaded into the output register.
// Reset (aresetn low, synchronous) empties the table and restores register defaults.
// A new word is accepted while an earlier result still waits; m_ready low only
// holds the next result back at its final step.
`timescale 1ns / 1ps

module centroid_track_association_unit import cta_pkg::*; #(
    parameter int MAX_TRACKS = DEF_MAX_TRACKS,
    parameter int COORD_BITS = DEF_COORD_BITS,
    localparam int CNT_W = $clog2(MAX_TRACKS + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready,
    // input words
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [OP_W-1:0]       s_opcode,
    input  logic [COORD_BITS-1:0] s_pos_x,
    input  logic [COORD_BITS-1:0] s_pos_y,
    input  logic [AREA_W-1:0]     s_area,
    input  logic [QK_W-1:0]       s_query_kind,
    // result words
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STAT_W-1:0]     m_status,
    output logic [ID_W-1:0]       m_track_id,
    output logic [COORD_BITS-1:0] m_out_x,
    output logic [COORD_BITS-1:0] m_out_y,
    output logic [CNT_W-1:0]      m_track_count
);

    logic [MD_W-1:0] match_radius_reg;
    logic [MT_W-1:0] max_tracks_reg;
    logic [HF_W-1:0] hold_frames_reg;
    logic            cfg_write;
    logic [1:0]      reg_sel;
    dp_cmd_t         cmd;
    dp_stat_t        stat;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_sel   = paddr[3:2];

    // Configuration register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_radius_reg <= RST_MAX_DIST;
            max_tracks_reg   <= RST_MAX_TRACKS;
            hold_frames_reg  <= RST_HOLD;
        end else if (cfg_write) begin
            case (reg_sel)
                REG_MAX_DIST:   match_radius_reg <= pwdata[MD_W-1:0];
                REG_MAX_TRACKS: max_tracks_reg   <= pwdata[MT_W-1:0];
                REG_HOLD:       hold_frames_reg  <= pwdata[HF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (reg_sel)
            REG_MAX_DIST:   prdata = DATA_W'(match_radius_reg);
            REG_MAX_TRACKS: prdata = DATA_W'(max_tracks_reg);
            REG_HOLD:       prdata = DATA_W'(hold_frames_reg);
            default:        prdata = '0;
        endcase
    end

    // Sequencer.
    cta_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Track table and arithmetic.
    cta_datapath #(
        .MAX_TRACKS (MAX_TRACKS),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .match_radius  (match_radius_reg),
        .max_tracks    (max_tracks_reg),
        .hold_frames   (hold_frames_reg),
        .s_opcode      (s_opcode),
        .s_pos_x       (s_pos_x),
        .s_pos_y       (s_pos_y),
        .s_area        (s_area),
        .s_query_kind  (s_query_kind),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_status      (m_status),
        .m_track_id    (m_track_id),
        .m_out_x       (m_out_x),
        .m_out_y       (m_out_y),
        .m_track_count (m_track_count)
    );

endmodule
